/* rtl/core/assert_macros.svh */
// Assertion macros shared by the duplicate filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SDF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDF_ASSERT(label, clk, rst, prop, msg)
`define SDF_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* rtl/core/sdf_pkg.sv */
// Types and constants of the sender duplicate filter.
package sdf_pkg;

   localparam int unsigned ADDR_FIELD_BITS = 16;
   localparam int unsigned SEQ_BITS        = 8;
   localparam int unsigned COUNT_BITS      = 32;

   typedef struct packed {
      logic [ADDR_FIELD_BITS-1:0] sender_address;
      logic [SEQ_BITS-1:0]        sequence_number;
   } req_type;

   typedef struct packed {
      logic                  is_duplicate;
      logic                  sender_was_known;
      logic [COUNT_BITS-1:0] frames_seen;
   } rsp_type;

   // control broadcast to every history cell
   typedef struct packed {
      logic compare;  // register match flags against the key
      logic commit;   // apply the table update
      logic shift;    // miss: insert at the head, entries move one cell down
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic same_seq;
   } cell_status_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_MATCH  = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

endpackage

/* rtl/core/sdf_cell.sv */
// One history entry: holds address and sequence, compares, shifts to its neighbor, takes a new sequence on a hit.
module sdf_cell #(
   parameter int unsigned KEY_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  sdf_pkg::cell_ctrl_type       ctrl,
   input  logic [KEY_BITS-1:0]          key_addr,
   input  logic [sdf_pkg::SEQ_BITS-1:0] key_seq,
   input  logic                         prev_valid,
   input  logic [KEY_BITS-1:0]          prev_addr,
   input  logic [sdf_pkg::SEQ_BITS-1:0] prev_seq,
   output logic                         entry_valid,
   output logic [KEY_BITS-1:0]          entry_addr,
   output logic [sdf_pkg::SEQ_BITS-1:0] entry_seq,
   output sdf_pkg::cell_status_type     status
);
   import sdf_pkg::*;

   logic                valid_ff, valid_in;
   logic [KEY_BITS-1:0] addr_ff, addr_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic                hit_ff, hit_in;
   logic                same_ff, same_in;

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      seq_in   = seq_ff;
      hit_in   = hit_ff;
      same_in  = same_ff;
      if (ctrl.compare) begin
         hit_in  = valid_ff && (addr_ff == key_addr);
         same_in = (seq_ff == key_seq);
      end
      if (ctrl.commit) begin
         if (ctrl.shift) begin
            valid_in = prev_valid;
            addr_in  = prev_addr;
            seq_in   = prev_seq;
         end else if (hit_ff && !same_ff) begin
            seq_in = key_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
         same_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
         same_ff  <= same_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      seq_ff  <= seq_in;
   end

   assign entry_valid     = valid_ff;
   assign entry_addr      = addr_ff;
   assign entry_seq       = seq_ff;
   assign status.hit      = hit_ff;
   assign status.same_seq = same_ff;

endmodule

/* rtl/core/sender_duplicate_filter_top.sv */
// An accepted word is registered as the key, its match flags are registered in ST_MATCH,
// and its result is registered in ST_COMMIT, which waits while an unread result is held;
// a compare pass then a commit pass go over the row of history cells, and a new word is taken as it commits.
// Reset clears all entry valid flags, the frame count and the control state at once;
// no clearing pass, the block is ready to take a word as soon as reset is released.
// Eviction is FIFO: a miss enters at cell 0 and the entry in the last cell drops out.
`include "assert_macros.svh"
module sender_duplicate_filter_top #(
   parameter int unsigned HISTORY_ENTRIES = 4,
   parameter int unsigned ADDRESS_BITS    = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sdf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sdf_pkg::rsp_type rsp_data
);
   import sdf_pkg::*;

   localparam int unsigned KEY_BITS =
      (ADDRESS_BITS < ADDR_FIELD_BITS) ? ADDRESS_BITS : ADDR_FIELD_BITS;

   state_type             state_ff, state_in;
   logic [KEY_BITS-1:0]   key_addr_ff, key_addr_in;
   logic [SEQ_BITS-1:0]   key_seq_ff, key_seq_in;
   logic [COUNT_BITS-1:0] frame_count_ff, frame_count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  commit_go;
   logic                  known;
   logic                  dup;
   cell_ctrl_type         ctrl;

   logic                  cell_valid [HISTORY_ENTRIES];
   logic [KEY_BITS-1:0]   cell_addr  [HISTORY_ENTRIES];
   logic [SEQ_BITS-1:0]   cell_seq   [HISTORY_ENTRIES];
   cell_status_type       cell_stat  [HISTORY_ENTRIES];
   logic [HISTORY_ENTRIES-1:0] hit_vec;
   logic [HISTORY_ENTRIES-1:0] dup_vec;

   // ---- cell row ----
   for (genvar i = 0; i < HISTORY_ENTRIES; i++) begin : g_cell
      if (i == 0) begin : g_head
         sdf_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .key_addr    (key_addr_ff),
            .key_seq     (key_seq_ff),
            .prev_valid  (1'b1),
            .prev_addr   (key_addr_ff),
            .prev_seq    (key_seq_ff),
            .entry_valid (cell_valid[i]),
            .entry_addr  (cell_addr[i]),
            .entry_seq   (cell_seq[i]),
            .status      (cell_stat[i])
         );
      end else begin : g_body
         sdf_cell #(.KEY_BITS(KEY_BITS)) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .key_addr    (key_addr_ff),
            .key_seq     (key_seq_ff),
            .prev_valid  (cell_valid[i-1]),
            .prev_addr   (cell_addr[i-1]),
            .prev_seq    (cell_seq[i-1]),
            .entry_valid (cell_valid[i]),
            .entry_addr  (cell_addr[i]),
            .entry_seq   (cell_seq[i]),
            .status      (cell_stat[i])
         );
      end
   end

   // the last cell's entry has no successor; it is evicted on a shift
   always_comb begin
      for (int i = 0; i < HISTORY_ENTRIES; i++) begin
         hit_vec[i] = cell_stat[i].hit;
         dup_vec[i] = cell_stat[i].hit && cell_stat[i].same_seq;
      end
   end

   assign known = |hit_vec;
   assign dup   = |dup_vec;

   // ---- control ----
   assign commit_go = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || commit_go;
   assign accept    = req_valid && req_ready;

   assign ctrl.compare = (state_ff == ST_MATCH);
   assign ctrl.commit  = commit_go;
   assign ctrl.shift   = !known;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_MATCH;
         end
         ST_MATCH: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (commit_go) state_in = accept ? ST_MATCH : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      key_addr_in = key_addr_ff;
      key_seq_in  = key_seq_ff;
      if (accept) begin
         key_addr_in = req_data.sender_address[KEY_BITS-1:0];
         key_seq_in  = req_data.sequence_number;
      end
   end

   always_comb begin
      frame_count_in = frame_count_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (commit_go) begin
         frame_count_in               = frame_count_ff + COUNT_BITS'(1);
         rsp_valid_in                 = 1'b1;
         rsp_data_in.is_duplicate     = dup;
         rsp_data_in.sender_was_known = known;
         rsp_data_in.frames_seen      = frame_count_ff + COUNT_BITS'(1);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frame_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_addr_ff <= key_addr_in;
      key_seq_ff  <= key_seq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---- checks ----
   `SDF_ASSERT(a_single_hit, clock, reset,
      (state_ff == ST_COMMIT) |-> $onehot0(hit_vec),
      "more than one history entry matched the sender")
   `SDF_ASSERT(a_dup_known, clock, reset,
      rsp_valid_ff |-> (rsp_data_ff.sender_was_known || !rsp_data_ff.is_duplicate),
      "duplicate word flagged for an unknown sender")
   `SDF_ASSERT(a_accept_match, clock, reset,
      accept |=> (state_ff == ST_MATCH),
      "accepted word did not enter the compare pass")
   `SDF_ASSERT(a_match_commit, clock, reset,
      (state_ff == ST_MATCH) |=> (state_ff == ST_COMMIT),
      "compare pass not followed by commit")
   `SDF_ASSERT(a_commit_rsp, clock, reset,
      commit_go |=> (rsp_valid_ff && (rsp_data_ff.frames_seen == frame_count_ff)),
      "committed word missing from the result register")

endmodule
